/* rtl/reliable_provisional_tracker_unit_assert.svh */
// Assertion macros shared by the tracker's checker.
// Needs nothing else; expects i_clk and i_rst_n in the scope of use.
`ifndef RELIABLE_PROVISIONAL_TRACKER_UNIT_ASSERT_SVH
`define RELIABLE_PROVISIONAL_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define RPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rpt_pkg.sv */
// Package for the reliable provisional tracker: request/result structs and codes.
// No dependencies.
package rpt_pkg;

    // Event opcodes
    localparam logic [2:0] OP_REQ_IN   = 3'd0;
    localparam logic [2:0] OP_REPLY_IN = 3'd1;
    localparam logic [2:0] OP_REQ_OUT  = 3'd2;
    localparam logic [2:0] OP_REPLY_OUT = 3'd3;
    localparam logic [2:0] OP_TIMEOUT  = 3'd4;

    // Method codes
    localparam logic [1:0] METH_INVITE = 2'd0;
    localparam logic [1:0] METH_PRACK  = 2'd1;

    // Modes
    localparam logic [1:0] MODE_DISABLED  = 2'd0;
    localparam logic [1:0] MODE_SUPPORTED = 2'd1;
    localparam logic [1:0] MODE_REQUIRED  = 2'd2;
    localparam logic [1:0] MODE_IGNORED   = 2'd3;
    localparam logic [1:0] MODE_RESET     = MODE_SUPPORTED;

    // Reject codes
    localparam logic [1:0] REJ_NONE = 2'd0;
    localparam logic [1:0] REJ_421  = 2'd1;
    localparam logic [1:0] REJ_420  = 2'd2;

    // Notification codes
    localparam logic [2:0] NOTE_NONE     = 3'd0;
    localparam logic [2:0] NOTE_FAILURE  = 3'd1;
    localparam logic [2:0] NOTE_REL_1XX  = 3'd2;
    localparam logic [2:0] NOTE_PRACK_OK = 3'd3;
    localparam logic [2:0] NOTE_NO_PRACK = 3'd4;

    // Header codes
    localparam logic [1:0] HDR_NONE      = 2'd0;
    localparam logic [1:0] HDR_SUPPORTED = 2'd1;
    localparam logic [1:0] HDR_REQUIRE   = 2'd2;

    // Status code bounds
    localparam logic [9:0] CODE_100 = 10'd100;
    localparam logic [9:0] CODE_200 = 10'd200;
    localparam logic [9:0] CODE_300 = 10'd300;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  method_kind;
        logic [9:0]  status_code;
        logic [31:0] seq_value;
        logic        supported_flag;
        logic        require_flag;
        logic        seq_header_present;
        logic        dialog_active;
        logic [9:0]  random_start;
    } t_rpt_req;

    typedef struct packed {
        logic        pass_on;
        logic [1:0]  reject_kind;
        logic        send_bye;
        logic [2:0]  notify_kind;
        logic [1:0]  add_header;
        logic        add_seq;
        logic [31:0] seq_out;
        logic        refuse_491;
    } t_rpt_res;

endpackage

/* rtl/reliable_provisional_tracker_unit.sv */
// An accepted request's result is written to the result register, or to the
// skid stage while the output is held. Throughput: one request per cycle
// while the skid stage is empty; the decision logic feeds the result register,
// with a one-entry skid stage behind it; upstream stalls only while it is full.
// Reset (synchronous, active low): empty result path, mode back to supported,
// upgrade flag, sequence numbers and confirmation cleared.
module reliable_provisional_tracker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rpt_pkg::t_rpt_req  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output rpt_pkg::t_rpt_res  o_data,
    input  logic               i_stall,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data
);

    logic [1:0]        r_base_mode;
    logic              r_upgraded, n_upgraded;
    logic [31:0]       r_seq_latest, n_seq_latest;
    logic [31:0]       r_seq_first, n_seq_first;
    logic              r_confirmed, n_confirmed;
    logic              r_out_valid, r_skid_valid;
    rpt_pkg::t_rpt_res r_out, r_skid;
    rpt_pkg::t_rpt_res res;
    logic [1:0]        mode;
    logic              accept, out_take, is_inv, is_prack, prov;

    // Handshake
    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign is_inv   = (i_data.method_kind == rpt_pkg::METH_INVITE);
    assign is_prack = (i_data.method_kind == rpt_pkg::METH_PRACK);
    assign prov     = (i_data.status_code > rpt_pkg::CODE_100) &&
                      (i_data.status_code < rpt_pkg::CODE_200);

    // Per-event decision and next state
    always_comb begin
        res          = '0;
        res.pass_on  = 1'b1;
        n_upgraded   = r_upgraded;
        n_seq_latest = r_seq_latest;
        n_seq_first  = r_seq_first;
        n_confirmed  = r_confirmed;
        mode = (r_base_mode == rpt_pkg::MODE_SUPPORTED && r_upgraded) ?
               rpt_pkg::MODE_REQUIRED : r_base_mode;

        if (mode != rpt_pkg::MODE_IGNORED) begin
            case (i_data.opcode)
                rpt_pkg::OP_REQ_IN: begin
                    if (is_inv) begin
                        if (mode == rpt_pkg::MODE_SUPPORTED) begin
                            if (i_data.supported_flag || i_data.require_flag)
                                n_upgraded = 1'b1;
                        end else if (mode == rpt_pkg::MODE_REQUIRED) begin
                            if (!(i_data.supported_flag || i_data.require_flag)) begin
                                res.reject_kind = rpt_pkg::REJ_421;
                                res.notify_kind = rpt_pkg::NOTE_FAILURE;
                                res.pass_on     = 1'b0;
                            end
                        end else if (i_data.require_flag) begin
                            res.reject_kind = rpt_pkg::REJ_420;
                            res.notify_kind = rpt_pkg::NOTE_FAILURE;
                            res.pass_on     = 1'b0;
                        end
                    end else if (is_prack && mode == rpt_pkg::MODE_REQUIRED) begin
                        // acknowledgment of the latest reliable 1xx
                        if (r_seq_first <= i_data.seq_value &&
                            i_data.seq_value == r_seq_latest)
                            n_confirmed = 1'b1;
                    end
                end
                rpt_pkg::OP_REPLY_IN: begin
                    if (i_data.dialog_active) begin
                        if (prov && is_inv) begin
                            if (mode == rpt_pkg::MODE_SUPPORTED && i_data.require_flag) begin
                                n_upgraded = 1'b1;
                                mode       = rpt_pkg::MODE_REQUIRED;
                            end
                            if (mode == rpt_pkg::MODE_REQUIRED) begin
                                if (!i_data.require_flag || i_data.seq_value == '0) begin
                                    res.send_bye    = 1'b1;
                                    res.notify_kind = rpt_pkg::NOTE_FAILURE;
                                end else begin
                                    res.notify_kind = rpt_pkg::NOTE_REL_1XX;
                                end
                            end
                        end else if (mode != rpt_pkg::MODE_DISABLED && is_prack) begin
                            // reply to our PRACK is absorbed
                            if (i_data.status_code >= rpt_pkg::CODE_300) begin
                                res.send_bye    = 1'b1;
                                res.notify_kind = rpt_pkg::NOTE_FAILURE;
                            end else if (i_data.status_code >= rpt_pkg::CODE_200) begin
                                res.notify_kind = rpt_pkg::NOTE_PRACK_OK;
                            end
                            res.pass_on = 1'b0;
                        end
                    end
                end
                rpt_pkg::OP_REQ_OUT: begin
                    if (is_inv && !i_data.require_flag) begin
                        if (mode == rpt_pkg::MODE_SUPPORTED)
                            res.add_header = rpt_pkg::HDR_SUPPORTED;
                        else if (mode == rpt_pkg::MODE_REQUIRED)
                            res.add_header = rpt_pkg::HDR_REQUIRE;
                    end
                end
                rpt_pkg::OP_REPLY_OUT: begin
                    if (is_inv) begin
                        if (prov) begin
                            if (mode == rpt_pkg::MODE_SUPPORTED) begin
                                if (!i_data.require_flag)
                                    res.add_header = rpt_pkg::HDR_SUPPORTED;
                            end else if (mode == rpt_pkg::MODE_REQUIRED) begin
                                if (!i_data.require_flag)
                                    res.add_header = rpt_pkg::HDR_REQUIRE;
                                if (!i_data.seq_header_present) begin
                                    if (r_seq_latest == '0) begin
                                        // fresh start number
                                        n_seq_latest = {22'd0, i_data.random_start} + 32'd1;
                                        n_seq_first  = n_seq_latest;
                                        n_confirmed  = 1'b0;
                                        res.add_seq  = 1'b1;
                                        res.seq_out  = n_seq_latest;
                                    end else if (!r_confirmed &&
                                                 r_seq_first == r_seq_latest) begin
                                        res.refuse_491 = 1'b1;
                                        res.pass_on    = 1'b0;
                                        res.add_header = rpt_pkg::HDR_NONE;
                                    end else begin
                                        n_seq_latest = r_seq_latest + 32'd1;
                                        res.add_seq  = 1'b1;
                                        res.seq_out  = n_seq_latest;
                                    end
                                end
                            end
                        end else if (i_data.status_code < rpt_pkg::CODE_300 &&
                                     mode == rpt_pkg::MODE_REQUIRED) begin
                            // final reply while a reliable 1xx is unacknowledged
                            if (r_seq_latest != '0 && !r_confirmed) begin
                                res.refuse_491 = 1'b1;
                                res.pass_on    = 1'b0;
                            end
                        end
                    end
                end
                rpt_pkg::OP_TIMEOUT: begin
                    if (prov && mode == rpt_pkg::MODE_REQUIRED &&
                        r_seq_latest == i_data.seq_value && is_inv)
                        res.notify_kind = rpt_pkg::NOTE_NO_PRACK;
                end
                default: begin
                end
            endcase
        end
    end

    // Configuration and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_mode  <= rpt_pkg::MODE_RESET;
            r_upgraded   <= 1'b0;
            r_seq_latest <= '0;
            r_seq_first  <= '0;
            r_confirmed  <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_base_mode <= i_cfg_data;
            if (accept) begin
                r_upgraded   <= n_upgraded;
                r_seq_latest <= n_seq_latest;
                r_seq_first  <= n_seq_first;
                r_confirmed  <= n_confirmed;
            end
        end
    end

    // Result register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid)
                r_out <= r_skid;
            else if (accept)
                r_out <= res;
        end else if (accept) begin
            r_skid <= res;
        end
    end

endmodule

/* rtl/rpt_checker.sv */
// Port-level checker for the reliable provisional tracker, bound to the top level.
// Depends on rpt_pkg and reliable_provisional_tracker_unit_assert.svh.
`include "reliable_provisional_tracker_unit_assert.svh"

module rpt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input rpt_pkg::t_rpt_res o_data,
    input logic              i_stall
);

    // result request holds while stalled
    `RPT_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "result dropped under stall")
    `RPT_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_data), "stalled result changed")
    // upstream only stalled while a result is pending
    `RPT_ASSERT_SAME(a_stall_full, o_stall, o_valid, "stall with empty result register")
    // sequence number only present when appended
    `RPT_ASSERT_SAME(a_seq_zero, o_valid && !o_data.add_seq, o_data.seq_out == '0, "stray seq_out")
    // refused reply carries no edits
    `RPT_ASSERT_SAME(a_refuse, o_valid && o_data.refuse_491, !o_data.pass_on && !o_data.add_seq && o_data.add_header == rpt_pkg::HDR_NONE, "491 with edits")

endmodule

bind reliable_provisional_tracker_unit rpt_checker u_rpt_checker (.*);

/* bench/tb_reliable_provisional_tracker_unit.sv */
// Self-checking bench for reliable_provisional_tracker_unit: directed script, then random traffic.
// Depends on rpt_pkg (request/result structs and codes) and the tracker RTL only.
`timescale 1ns / 1ps

module tb_reliable_provisional_tracker_unit;
    import rpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 75;

    typedef struct {
        bit         cfg_write;
        logic [1:0] cfg_mode;
        bit         typed;
        t_rpt_req   rq;
        t_rpt_res   res;
    } t_script_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    t_rpt_req i_data;
    logic     o_stall;
    logic     o_valid;
    t_rpt_res o_data;
    logic     i_stall;
    logic     i_cfg_we;
    logic [1:0] i_cfg_data;

    // Tracker state as the bench sees it
    logic [1:0]  mode_q         = MODE_RESET;
    logic        upgraded_q     = 1'b0;
    logic [31:0] seq_latest_q   = '0;
    logic [31:0] seq_first_q    = '0;
    logic        confirmed_q    = 1'b0;

    t_rpt_res    pending_results[$];
    t_script_row script[$];

    int  errors       = 0;
    int  n_requests   = 0;
    int  n_checked    = 0;
    int  n_refused    = 0;
    int  idle_cycles  = 0;
    bit  calm         = 1'b0;
    bit  hold_req     = 1'b0;
    bit  hold_done    = 1'b0;

    reliable_provisional_tracker_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted result of one request; updates the tracked state
    function automatic t_rpt_res track_event(input t_rpt_req rq);
        logic [1:0] mode;
        logic       is_inv;
        logic       is_prack;
        logic       prov;
        t_rpt_res   r;
        r         = '0;
        r.pass_on = 1'b1;
        mode      = (mode_q == MODE_SUPPORTED && upgraded_q) ? MODE_REQUIRED : mode_q;
        is_inv    = (rq.method_kind == METH_INVITE);
        is_prack  = (rq.method_kind == METH_PRACK);
        prov      = (rq.status_code > CODE_100) && (rq.status_code < CODE_200);
        if (mode != MODE_IGNORED) begin
            case (rq.opcode)
                OP_REQ_IN: begin
                    if (is_inv) begin
                        if (mode == MODE_SUPPORTED) begin
                            if (rq.supported_flag || rq.require_flag) upgraded_q = 1'b1;
                        end else if (mode == MODE_REQUIRED) begin
                            if (!(rq.supported_flag || rq.require_flag)) begin
                                r.reject_kind = REJ_421;
                                r.notify_kind = NOTE_FAILURE;
                                r.pass_on     = 1'b0;
                            end
                        end else if (rq.require_flag) begin
                            r.reject_kind = REJ_420;
                            r.notify_kind = NOTE_FAILURE;
                            r.pass_on     = 1'b0;
                        end
                    end else if (is_prack && mode == MODE_REQUIRED) begin
                        // PRACK confirms only the latest reliable 1xx
                        if (seq_first_q <= rq.seq_value && rq.seq_value == seq_latest_q)
                            confirmed_q = 1'b1;
                    end
                end
                OP_REPLY_IN: begin
                    if (rq.dialog_active) begin
                        if (prov && is_inv) begin
                            if (mode == MODE_SUPPORTED && rq.require_flag) begin
                                upgraded_q = 1'b1;
                                mode       = MODE_REQUIRED;
                            end
                            if (mode == MODE_REQUIRED) begin
                                if (!rq.require_flag || rq.seq_value == 32'd0) begin
                                    r.send_bye    = 1'b1;
                                    r.notify_kind = NOTE_FAILURE;
                                end else begin
                                    r.notify_kind = NOTE_REL_1XX;
                                end
                            end
                        end else if (mode != MODE_DISABLED && is_prack) begin
                            if (rq.status_code >= CODE_300) begin
                                r.send_bye    = 1'b1;
                                r.notify_kind = NOTE_FAILURE;
                            end else if (rq.status_code >= CODE_200) begin
                                r.notify_kind = NOTE_PRACK_OK;
                            end
                            r.pass_on = 1'b0;
                        end
                    end
                end
                OP_REQ_OUT: begin
                    if (is_inv && !rq.require_flag) begin
                        if (mode == MODE_SUPPORTED)     r.add_header = HDR_SUPPORTED;
                        else if (mode == MODE_REQUIRED) r.add_header = HDR_REQUIRE;
                    end
                end
                OP_REPLY_OUT: begin
                    if (is_inv && prov) begin
                        if (mode == MODE_SUPPORTED) begin
                            if (!rq.require_flag) r.add_header = HDR_SUPPORTED;
                        end else if (mode == MODE_REQUIRED) begin
                            if (!rq.require_flag) r.add_header = HDR_REQUIRE;
                            if (!rq.seq_header_present) begin
                                if (seq_latest_q == 32'd0) begin
                                    // first reliable 1xx: fresh start number
                                    seq_latest_q = {22'd0, rq.random_start} + 32'd1;
                                    confirmed_q  = 1'b0;
                                    seq_first_q  = seq_latest_q;
                                    r.add_seq    = 1'b1;
                                    r.seq_out    = seq_latest_q;
                                end else if (!confirmed_q && seq_first_q == seq_latest_q) begin
                                    r.refuse_491 = 1'b1;
                                    r.pass_on    = 1'b0;
                                    r.add_header = HDR_NONE;
                                end else begin
                                    seq_latest_q = seq_latest_q + 32'd1;
                                    r.add_seq    = 1'b1;
                                    r.seq_out    = seq_latest_q;
                                end
                            end
                        end
                    end else if (is_inv && rq.status_code < CODE_300
                                 && mode == MODE_REQUIRED) begin
                        if (seq_latest_q != 32'd0 && !confirmed_q) begin
                            r.refuse_491 = 1'b1;
                            r.pass_on    = 1'b0;
                        end
                    end
                end
                OP_TIMEOUT: begin
                    if (prov && mode == MODE_REQUIRED && seq_latest_q == rq.seq_value && is_inv)
                        r.notify_kind = NOTE_NO_PRACK;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic t_rpt_req ev(input logic [2:0] op, input logic [1:0] meth,
                                    input logic [9:0] code, input logic [31:0] seq,
                                    input logic sup, input logic req, input logic seqhdr,
                                    input logic active, input logic [9:0] rnd);
        t_rpt_req rq;
        rq.opcode             = op;
        rq.method_kind        = meth;
        rq.status_code        = code;
        rq.seq_value          = seq;
        rq.supported_flag     = sup;
        rq.require_flag       = req;
        rq.seq_header_present = seqhdr;
        rq.dialog_active      = active;
        rq.random_start       = rnd;
        return rq;
    endfunction

    function automatic t_rpt_res outcome(input logic pass, input logic [1:0] rej,
                                         input logic [2:0] note, input logic [1:0] hdr,
                                         input logic aseq, input logic [31:0] sout,
                                         input logic r491);
        t_rpt_res r;
        r             = '0;
        r.pass_on     = pass;
        r.reject_kind = rej;
        r.notify_kind = note;
        r.add_header  = hdr;
        r.add_seq     = aseq;
        r.seq_out     = sout;
        r.refuse_491  = r491;
        return r;
    endfunction

    task automatic add_cfg(input logic [1:0] m);
        t_script_row row;
        row           = '{default: '0};
        row.cfg_write = 1'b1;
        row.cfg_mode  = m;
        script.push_back(row);
    endtask

    task automatic add_req(input t_rpt_req rq, input bit typed, input t_rpt_res res);
        t_script_row row;
        row       = '{default: '0};
        row.rq    = rq;
        row.typed = typed;
        row.res   = res;
        script.push_back(row);
    endtask

    // Random request: either a plausible dialog step or pure noise
    function automatic t_rpt_req random_req(input bit well_formed);
        t_rpt_req rq;
        rq.opcode             = 3'($urandom_range(7));
        rq.method_kind        = 2'($urandom_range(3));
        rq.status_code        = 10'($urandom_range(699));
        rq.seq_value          = $urandom();
        rq.supported_flag     = 1'($urandom_range(1));
        rq.require_flag       = 1'($urandom_range(1));
        rq.seq_header_present = 1'($urandom_range(1));
        rq.dialog_active      = 1'($urandom_range(1));
        rq.random_start       = 10'($urandom_range(1023));
        case ($urandom_range(7))
            0: rq.seq_value = '0;
            1: rq.seq_value = '1;
            default: ;
        endcase
        if (well_formed) begin
            rq.seq_header_present = ($urandom_range(9) == 0);
            rq.dialog_active      = ($urandom_range(9) != 0);
            rq.method_kind        = METH_INVITE;
            case ($urandom_range(6))
                0: rq.opcode = OP_REQ_IN;
                1: begin
                    rq.opcode      = OP_REPLY_OUT;
                    rq.status_code = 10'($urandom_range(199, 101));
                end
                2: begin
                    rq.opcode      = OP_REQ_IN;
                    rq.method_kind = METH_PRACK;
                    if ($urandom_range(3) != 0) rq.seq_value = seq_latest_q;
                    else rq.seq_value = seq_latest_q + $urandom_range(2) - 1;
                end
                3: begin
                    rq.opcode      = OP_REPLY_OUT;
                    rq.status_code = $urandom_range(1) ? 10'($urandom_range(299, 100))
                                                       : 10'($urandom_range(699, 300));
                end
                4: begin
                    rq.opcode       = OP_REPLY_IN;
                    rq.status_code  = 10'($urandom_range(199, 101));
                    rq.require_flag = ($urandom_range(5) != 0);
                end
                5: begin
                    rq.opcode      = OP_REPLY_IN;
                    rq.method_kind = METH_PRACK;
                    rq.status_code = 10'($urandom_range(699, 100));
                end
                default: begin
                    rq.opcode      = OP_TIMEOUT;
                    rq.status_code = 10'($urandom_range(199, 101));
                    if ($urandom_range(3) != 0) rq.seq_value = seq_latest_q;
                end
            endcase
        end
        return rq;
    endfunction

    // Offer one request, wait for acceptance, queue its expected result
    task automatic send_req(input t_rpt_req rq, input bit typed, input t_rpt_res res);
        t_rpt_res pred;
        while (!calm && $urandom_range(99) < 29) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= rq;
        do @(posedge i_clk); while (o_stall);
        pred = track_event(rq);
        pending_results.push_back(typed ? res : pred);
        n_requests++;
    endtask

    // Stop offering and let every outstanding result come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        mode_q = m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_stall <= (!calm && $urandom_range(99) < 29);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_rpt_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h, expected nothing", $time, o_data);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (want.refuse_491) n_refused++;
                check_field("pass_on",     want.pass_on,     o_data.pass_on);
                check_field("reject_kind", want.reject_kind, o_data.reject_kind);
                check_field("send_bye",    want.send_bye,    o_data.send_bye);
                check_field("notify_kind", want.notify_kind, o_data.notify_kind);
                check_field("add_header",  want.add_header,  o_data.add_header);
                check_field("add_seq",     want.add_seq,     o_data.add_seq);
                check_field("seq_out",     want.seq_out,     o_data.seq_out);
                check_field("refuse_491",  want.refuse_491,  o_data.refuse_491);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("tb_reliable_provisional_tracker_unit: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        logic [1:0] phase_modes [6];
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        phase_modes = '{MODE_REQUIRED, MODE_REQUIRED, MODE_DISABLED,
                        MODE_SUPPORTED, MODE_IGNORED, MODE_REQUIRED};

        // Directed script; typed results only where obvious
        add_req(ev(OP_REQ_OUT, METH_INVITE, 10'd0, 32'd0, 0, 0, 0, 1, 10'd0), 1,
                outcome(1, REJ_NONE, NOTE_NONE, HDR_SUPPORTED, 0, 32'd0, 0));
        add_req(ev(OP_REQ_IN, METH_INVITE, 10'd0, 32'd0, 0, 0, 0, 1, 10'd0), 1,
                outcome(1, REJ_NONE, NOTE_NONE, HDR_NONE, 0, 32'd0, 0));
        add_cfg(MODE_DISABLED);
        add_req(ev(OP_REQ_IN, METH_INVITE, 10'd0, 32'd0, 0, 1, 0, 1, 10'd0), 1,
                outcome(0, REJ_420, NOTE_FAILURE, HDR_NONE, 0, 32'd0, 0));
        add_req(ev(OP_REPLY_IN, METH_PRACK, 10'd200, 32'd5, 1, 1, 0, 1, 10'd0), 0, '0);
        add_cfg(MODE_REQUIRED);
        add_req(ev(OP_REQ_IN, METH_INVITE, 10'd0, 32'd0, 0, 0, 0, 1, 10'd0), 1,
                outcome(0, REJ_421, NOTE_FAILURE, HDR_NONE, 0, 32'd0, 0));
        add_req(ev(OP_REQ_OUT, METH_INVITE, 10'd0, 32'd0, 0, 0, 0, 1, 10'd0), 1,
                outcome(1, REJ_NONE, NOTE_NONE, HDR_REQUIRE, 0, 32'd0, 0));
        // first reliable 1xx with the largest start value
        add_req(ev(OP_REPLY_OUT, METH_INVITE, 10'd180, 32'd0, 0, 0, 0, 1, 10'h3ff), 1,
                outcome(1, REJ_NONE, NOTE_NONE, HDR_REQUIRE, 1, 32'd1024, 0));
        // second 1xx before any PRACK is refused, as is an unacknowledged 2xx
        add_req(ev(OP_REPLY_OUT, METH_INVITE, 10'd183, 32'd0, 0, 0, 0, 1, 10'd7), 1,
                outcome(0, REJ_NONE, NOTE_NONE, HDR_NONE, 0, 32'd0, 1));
        add_req(ev(OP_REPLY_OUT, METH_INVITE, 10'd200, 32'd0, 0, 0, 0, 1, 10'd0), 0, '0);
        add_req(ev(OP_TIMEOUT, METH_INVITE, 10'd180, 32'd1024, 0, 0, 0, 1, 10'd0), 0, '0);
        add_req(ev(OP_REQ_IN, METH_PRACK, 10'd0, 32'd1024, 0, 0, 0, 1, 10'd0), 0, '0);
        add_req(ev(OP_REPLY_OUT, METH_INVITE, 10'd180, 32'd0, 0, 0, 1, 1, 10'd0), 0, '0);
        add_req(ev(OP_REPLY_OUT, METH_INVITE, 10'd199, 32'd0, 1, 1, 0, 1, 10'd0), 0, '0);
        // final reply at or below 100
        add_req(ev(OP_REPLY_OUT, METH_INVITE, 10'd100, 32'd0, 0, 0, 0, 1, 10'd0), 0, '0);
        add_req(ev(OP_REPLY_IN, METH_INVITE, 10'd180, 32'd0, 1, 1, 0, 1, 10'd0), 0, '0);
        add_req(ev(OP_REPLY_IN, METH_INVITE, 10'd180, 32'd9, 1, 1, 0, 0, 10'd0), 0, '0);
        add_req(ev(OP_REPLY_IN, METH_PRACK, 10'd699, 32'd0, 0, 0, 0, 1, 10'd0), 0, '0);
        add_req(ev(OP_REPLY_IN, METH_PRACK, 10'd200, 32'd0, 0, 0, 0, 1, 10'd0), 0, '0);
        add_req(ev(OP_REPLY_IN, METH_INVITE, 10'd101, 32'hffff_ffff, 0, 1, 0, 1, 10'd0),
                0, '0);
        // unknown opcodes and method code 3 do nothing
        add_req(ev(3'd7, METH_INVITE, 10'd180, 32'd0, 1, 1, 1, 1, 10'h3ff), 1,
                outcome(1, REJ_NONE, NOTE_NONE, HDR_NONE, 0, 32'd0, 0));
        add_req(ev(3'd5, METH_PRACK, 10'd0, 32'd0, 0, 0, 0, 0, 10'd0), 0, '0);
        add_req(ev(OP_REQ_OUT, 2'd3, 10'd0, 32'd0, 0, 0, 0, 1, 10'd0), 0, '0);
        add_cfg(MODE_IGNORED);
        add_req(ev(OP_REQ_IN, METH_INVITE, 10'd0, 32'd0, 0, 1, 0, 1, 10'd0), 1,
                outcome(1, REJ_NONE, NOTE_NONE, HDR_NONE, 0, 32'd0, 0));
        // peer's Require upgrades supported to required; a mode write keeps it
        add_cfg(MODE_SUPPORTED);
        add_req(ev(OP_REPLY_IN, METH_INVITE, 10'd180, 32'd3, 0, 1, 0, 1, 10'd0), 0, '0);
        add_cfg(MODE_SUPPORTED);
        add_req(ev(OP_REQ_OUT, METH_INVITE, 10'd0, 32'd0, 1, 0, 0, 1, 10'd0), 0, '0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].cfg_write) begin
                wait_drained();
                write_mode(script[i].cfg_mode);
            end else begin
                send_req(script[i].rq, script[i].typed, script[i].res);
            end
        end

        // Random phases, one mode each; one calm, one with the long hold-off
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            write_mode(phase_modes[ph]);
            calm = (ph == 1);
            if (ph == 3) hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_req(random_req($urandom_range(99) < 70), 0, '0);
        end

        calm = 1'b0;
        wait_drained();
        repeat (5) @(posedge i_clk);

        $display("Sent %0d requests over all four modes; %0d results checked, %0d of them 491.",
                 n_requests, n_checked, n_refused);
        if (errors == 0) begin
            $display("tb_reliable_provisional_tracker_unit: clean");
        end else begin
            $display("tb_reliable_provisional_tracker_unit: errors");
        end
        $finish;
    end

endmodule

/* reliable_provisional_tracker_unit.f */
+incdir+rtl
rtl/rpt_pkg.sv
rtl/reliable_provisional_tracker_unit.sv
rtl/rpt_checker.sv
bench/tb_reliable_provisional_tracker_unit.sv
